// ===== rtl/core/button_gesture_detector_core_macros.svh =====
`ifndef BUTTON_GESTURE_DETECTOR_CORE_MACROS_SVH
`define BUTTON_GESTURE_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define BGD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define BGD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bgd_pkg.sv =====
package bgd_pkg;

	localparam int NUM_BUTTONS = 3;
	localparam int TIME_BITS   = 32;
	localparam int IDX_BITS    = 2;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [1:0]           RST_ENABLED    = 2'd0;
	localparam logic [15:0]          RST_DEBOUNCE   = 16'd50;
	localparam logic [15:0]          RST_DOUBLE     = 16'd300;
	localparam logic [15:0]          RST_HOLD       = 16'd500;
	localparam logic [TIME_BITS-1:0] RST_LONG       = TIME_BITS'(1500);

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_DEBOUNCE = 2'd1,
		PH_PRESSED  = 2'd2,
		PH_LONG     = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_PRESSED  = 3'd0,
		EV_RELEASED = 3'd1,
		EV_CLICKED  = 3'd2,
		EV_DOUBLE   = 3'd3,
		EV_LONG     = 3'd4,
		EV_HOLD     = 3'd5
	} ev_code_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_ENABLED  = 3'd0,
		CFG_DEBOUNCE = 3'd1,
		CFG_DOUBLE   = 3'd2,
		CFG_HOLD     = 3'd3,
		CFG_LONG     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0] levels;
		logic [TIME_BITS-1:0]   now_ms;
	} tick_t;

	typedef struct packed {
		logic [2:0]          event_code;
		logic [IDX_BITS-1:0] button_index;
		logic                last_of_run;
	} evt_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic emit2;
		logic click;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic at_end;
		logic ev_two;
		logic blocked;
	} sts_t;

endpackage

// ===== rtl/core/button_gesture_detector_core.sv =====
// Button gesture detector.
// tick channel (tick_valid/tick_ready, payload tick): one poll item with the
//   raw active-low button levels and a millisecond timestamp.
// evt channel (evt_valid/evt_ready, payload evt): one item per gesture event;
//   last_of_run marks the final event of a tick. A tick with no events gives
//   no items.
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): register writes,
//   always ready; write only while no tick is in flight.
// Timing: a tick is accepted only while the controller is idle. The enabled
//   buttons are then visited one per cycle by the shared compare datapath
//   while evt is not blocked, with an extra EMIT2 step for each button giving
//   two events; then SCAN sees the end of the scan, CLICK checks the click
//   timeout, FLUSH closes the run and the controller returns to IDLE.
// Each event is held one step so the last one can be flagged; a stalled evt
//   receiver stops the scan only when both that hold stage and the output
//   register are full.
// Reset: all buttons idle, no pending click, registers at their defaults.
module button_gesture_detector_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick_valid,
	output logic                              tick_ready,
	input  bgd_pkg::tick_t                    tick,
	output logic                              evt_valid,
	input  logic                              evt_ready,
	output bgd_pkg::evt_t                     evt,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bgd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [bgd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	bgd_pkg::cmd_t cmd;
	bgd_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	bgd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	bgd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt)
	);

endmodule

// ===== rtl/core/bgd_ctrl.sv =====
module bgd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tick_valid,
	output logic          tick_ready,
	input  bgd_pkg::sts_t sts,
	output bgd_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_EMIT2 = 5'b00100,
		ST_CLICK = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (tick_valid) begin
					cmd.start = 1'b1;
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.at_end) begin
					state_nxt = ST_CLICK;
				end else if (!sts.blocked) begin
					cmd.scan = 1'b1;
					if (sts.ev_two) begin
						state_nxt = ST_EMIT2;
					end
				end
			end
			ST_EMIT2: begin
				if (!sts.blocked) begin
					cmd.emit2 = 1'b1;
					state_nxt = ST_SCAN;
				end
			end
			ST_CLICK: begin
				if (!sts.blocked) begin
					cmd.click = 1'b1;
					state_nxt = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!sts.blocked) begin
					cmd.flush = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign tick_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/core/bgd_datapath.sv =====
`include "button_gesture_detector_core_macros.svh"

module bgd_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bgd_pkg::tick_t                      tick,
	input  logic                                cfg_valid,
	input  logic [bgd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [bgd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  bgd_pkg::cmd_t                       cmd,
	output bgd_pkg::sts_t                       sts,
	output logic                                evt_valid,
	input  logic                                evt_ready,
	output bgd_pkg::evt_t                       evt
);

	localparam int TB = bgd_pkg::TIME_BITS;
	localparam int IB = bgd_pkg::IDX_BITS;
	localparam int NB = bgd_pkg::NUM_BUTTONS;

	// configuration
	logic [1:0]    enabled_q;
	logic [15:0]   debounce_q;
	logic [15:0]   double_q;
	logic [15:0]   hold_int_q;
	logic [TB-1:0] long_q;

	// tick and scan position
	logic [NB-1:0] levels_q;
	logic [TB-1:0] now_q;
	logic [IB-1:0] idx_q;
	logic [IB-1:0] cnt_q;

	// per-button and shared gesture state
	bgd_pkg::phase_t phase_q [NB];
	logic [TB-1:0]   press_time_q [NB];
	logic [TB-1:0]   hold_time_q [NB];
	logic            click_pend_q;
	logic [TB-1:0]   click_time_q;

	// held item and output register
	logic              pend_vld_q;
	bgd_pkg::ev_code_t pend_code_q;
	logic [IB-1:0]     pend_idx_q;
	bgd_pkg::ev_code_t ev2_q;
	logic              out_vld_q;
	bgd_pkg::evt_t     out_q;

	bgd_pkg::phase_t   cur_phase, nxt_phase;
	logic              rel;
	logic [TB-1:0]     e_press, e_hold, e_click;
	logic              set_press, clr_hold, set_hold, set_click, clr_click;
	logic              ev1_vld, ev2_vld;
	bgd_pkg::ev_code_t ev1, ev2;
	logic              click_fire;
	logic              push;
	bgd_pkg::ev_code_t push_code;
	logic [IB-1:0]     push_idx;
	logic              clamp;

	assign cur_phase = phase_q[idx_q];
	assign rel       = levels_q[idx_q];
	assign e_press   = now_q - press_time_q[idx_q];
	assign e_hold    = now_q - hold_time_q[idx_q];
	assign e_click   = now_q - click_time_q;
	assign click_fire = click_pend_q && (e_click >= {{(TB-16){1'b0}}, double_q});
	assign clamp     = ({{(32-2){1'b0}}, enabled_q} > 32'(NB));

	always_comb begin
		nxt_phase = cur_phase;
		set_press = 1'b0;
		clr_hold  = 1'b0;
		set_hold  = 1'b0;
		set_click = 1'b0;
		clr_click = 1'b0;
		ev1_vld   = 1'b0;
		ev1       = bgd_pkg::EV_PRESSED;
		ev2_vld   = 1'b0;
		ev2       = bgd_pkg::EV_RELEASED;
		case (cur_phase)
			bgd_pkg::PH_IDLE: begin
				if (!rel) begin
					nxt_phase = bgd_pkg::PH_DEBOUNCE;
					set_press = 1'b1;
					clr_hold  = 1'b1;
				end
			end
			bgd_pkg::PH_DEBOUNCE: begin
				if (rel) begin
					nxt_phase = bgd_pkg::PH_IDLE;
				end else if (e_press >= {{(TB-16){1'b0}}, debounce_q}) begin
					nxt_phase = bgd_pkg::PH_PRESSED;
					set_press = 1'b1;
					ev1_vld   = 1'b1;
					ev1       = bgd_pkg::EV_PRESSED;
				end
			end
			bgd_pkg::PH_PRESSED: begin
				if (rel) begin
					nxt_phase = bgd_pkg::PH_IDLE;
					ev1_vld   = 1'b1;
					if (click_pend_q && (e_click < {{(TB-16){1'b0}}, double_q})) begin
						ev1       = bgd_pkg::EV_DOUBLE;
						ev2_vld   = 1'b1;
						ev2       = bgd_pkg::EV_RELEASED;
						clr_click = 1'b1;
					end else begin
						ev1       = bgd_pkg::EV_RELEASED;
						set_click = 1'b1;
					end
				end else if (e_press >= long_q) begin
					nxt_phase = bgd_pkg::PH_LONG;
					set_hold  = 1'b1;
					ev1_vld   = 1'b1;
					ev1       = bgd_pkg::EV_LONG;
					ev2_vld   = 1'b1;
					ev2       = bgd_pkg::EV_HOLD;
				end
			end
			bgd_pkg::PH_LONG: begin
				if (rel) begin
					nxt_phase = bgd_pkg::PH_IDLE;
					ev1_vld   = 1'b1;
					ev1       = bgd_pkg::EV_RELEASED;
				end else if (e_hold >= {{(TB-16){1'b0}}, hold_int_q}) begin
					set_hold = 1'b1;
					ev1_vld  = 1'b1;
					ev1      = bgd_pkg::EV_HOLD;
				end
			end
			default: begin
				nxt_phase = cur_phase;
			end
		endcase
	end

	always_comb begin
		push      = 1'b0;
		push_code = ev1;
		push_idx  = idx_q;
		if (cmd.scan && ev1_vld) begin
			push = 1'b1;
		end else if (cmd.emit2) begin
			push      = 1'b1;
			push_code = ev2_q;
		end else if (cmd.click && click_fire) begin
			push      = 1'b1;
			push_code = bgd_pkg::EV_CLICKED;
			push_idx  = '0;
		end
	end

	assign sts.at_end  = (idx_q >= cnt_q);
	assign sts.ev_two  = ev2_vld;
	assign sts.blocked = pend_vld_q && out_vld_q && !evt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= bgd_pkg::RST_ENABLED;
			debounce_q <= bgd_pkg::RST_DEBOUNCE;
			double_q   <= bgd_pkg::RST_DOUBLE;
			hold_int_q <= bgd_pkg::RST_HOLD;
			long_q     <= bgd_pkg::RST_LONG;
		end else if (cfg_valid) begin
			case (cfg_index)
				bgd_pkg::CFG_ENABLED:  enabled_q  <= cfg_data[1:0];
				bgd_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data[15:0];
				bgd_pkg::CFG_DOUBLE:   double_q   <= cfg_data[15:0];
				bgd_pkg::CFG_HOLD:     hold_int_q <= cfg_data[15:0];
				bgd_pkg::CFG_LONG:     long_q     <= cfg_data[TB-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			levels_q <= tick.levels;
			now_q    <= tick.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else if (cmd.start) begin
			idx_q <= '0;
			cnt_q <= clamp ? IB'(NB) : enabled_q;
		end else if ((cmd.scan && !ev2_vld) || cmd.emit2) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NB; b++) begin
				phase_q[b]      <= bgd_pkg::PH_IDLE;
				press_time_q[b] <= '0;
				hold_time_q[b]  <= '0;
			end
			click_pend_q <= 1'b0;
			click_time_q <= '0;
		end else begin
			if (cmd.scan) begin
				phase_q[idx_q] <= nxt_phase;
				if (set_press) press_time_q[idx_q] <= now_q;
				if (clr_hold)  hold_time_q[idx_q]  <= '0;
				if (set_hold)  hold_time_q[idx_q]  <= now_q;
				if (set_click) begin
					click_pend_q <= 1'b1;
					click_time_q <= now_q;
				end
				if (clr_click) click_pend_q <= 1'b0;
			end
			if (cmd.click && click_fire) begin
				click_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			ev2_q <= ev2;
		end
		if (push) begin
			pend_code_q <= push_code;
			pend_idx_q  <= push_idx;
		end
		if ((push || cmd.flush) && pend_vld_q) begin
			out_q.event_code   <= pend_code_q;
			out_q.button_index <= pend_idx_q;
			out_q.last_of_run  <= cmd.flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (push) begin
				pend_vld_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_vld_q <= 1'b0;
			end
			if ((push || cmd.flush) && pend_vld_q) begin
				out_vld_q <= 1'b1;
			end else if (evt_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign evt_valid = out_vld_q;
	assign evt       = out_q;

	`BGD_ASSERT_IMP(a_scan_in_range, cmd.scan, idx_q < cnt_q, "scan past enabled buttons")
	`BGD_ASSERT_NXT(a_flush_drains, cmd.flush, !pend_vld_q, "held item left after flush")
	`BGD_ASSERT_IMP(a_second_code, cmd.emit2,
		(ev2_q == bgd_pkg::EV_RELEASED) || (ev2_q == bgd_pkg::EV_HOLD),
		"bad second item code")
	`BGD_ASSERT_IMP(a_start_clean, cmd.start, !pend_vld_q, "held item at tick start")

endmodule

// ===== verif/button_gesture_detector_core_checker.sv =====
module button_gesture_detector_core_checker
	import bgd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tick_valid,
	input  logic                      tick_ready,
	input  tick_t                     tick,
	input  logic                      evt_valid,
	input  logic                      evt_ready,
	input  evt_t                      evt,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output int unsigned               fail_count,
	output int unsigned               outstanding
);

	localparam int PRINT_CAP = 40;

	logic [1:0]           n_enabled;
	logic [15:0]          debounce_ms;
	logic [15:0]          window_ms;
	logic [15:0]          repeat_ms;
	logic [TIME_BITS-1:0] long_ms;

	phase_t               btn_phase [NUM_BUTTONS];
	logic [TIME_BITS-1:0] pressed_at[NUM_BUTTONS];
	logic [TIME_BITS-1:0] held_at   [NUM_BUTTONS];
	logic                 click_armed;
	logic [TIME_BITS-1:0] armed_at;

	evt_t expected_q[$];

	task automatic report(input string msg);
		if (fail_count < PRINT_CAP)
			$display("%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic logic [TIME_BITS-1:0] since(input logic [TIME_BITS-1:0] now,
			input logic [TIME_BITS-1:0] then);
		return now - then;
	endfunction

	function automatic void add_expected(input ev_code_t code, input int idx);
		evt_t e;
		e.event_code   = code;
		e.button_index = IDX_BITS'(idx);
		e.last_of_run  = 1'b0;
		expected_q.push_back(e);
	endfunction

	function automatic void predict_tick(input tick_t t);
		int   first;
		int   scan;
		int   i;
		logic up;
		first = expected_q.size();
		scan  = (n_enabled > NUM_BUTTONS) ? NUM_BUTTONS : int'(n_enabled);
		for (i = 0; i < scan; i++) begin
			up = t.levels[i];
			case (btn_phase[i])
			PH_IDLE: begin
				if (!up) begin
					btn_phase[i]  = PH_DEBOUNCE;
					pressed_at[i] = t.now_ms;
					held_at[i]    = '0;
				end
			end
			PH_DEBOUNCE: begin
				if (up) begin
					btn_phase[i] = PH_IDLE;
				end else if (since(t.now_ms, pressed_at[i]) >= debounce_ms) begin
					btn_phase[i]  = PH_PRESSED;
					pressed_at[i] = t.now_ms;
					add_expected(EV_PRESSED, i);
				end
			end
			PH_PRESSED: begin
				if (up) begin
					btn_phase[i] = PH_IDLE;
					if (click_armed && since(t.now_ms, armed_at) < window_ms) begin
						add_expected(EV_DOUBLE, i);
						click_armed = 1'b0;
					end else begin
						click_armed = 1'b1;
						armed_at    = t.now_ms;
					end
					add_expected(EV_RELEASED, i);
				end else if (since(t.now_ms, pressed_at[i]) >= long_ms) begin
					btn_phase[i] = PH_LONG;
					held_at[i]   = t.now_ms;
					add_expected(EV_LONG, i);
					add_expected(EV_HOLD, i);
				end
			end
			default: begin
				if (up) begin
					btn_phase[i] = PH_IDLE;
					add_expected(EV_RELEASED, i);
				end else if (since(t.now_ms, held_at[i]) >= repeat_ms) begin
					held_at[i] = t.now_ms;
					add_expected(EV_HOLD, i);
				end
			end
			endcase
		end
		// window expiry is checked every tick, even with nothing scanned
		if (click_armed && since(t.now_ms, armed_at) >= window_ms) begin
			click_armed = 1'b0;
			add_expected(EV_CLICKED, 0);
		end
		if (expected_q.size() > first)
			expected_q[expected_q.size() - 1].last_of_run = 1'b1;
	endfunction

	task automatic check_event(input evt_t got);
		evt_t want;
		if (expected_q.size() == 0) begin
			report($sformatf("unexpected event code %0d button %0d last %0b",
				got.event_code, got.button_index, got.last_of_run));
		end else begin
			want = expected_q.pop_front();
			if (got.event_code !== want.event_code)
				report($sformatf("event_code %0d, expected %0d",
					got.event_code, want.event_code));
			if (got.button_index !== want.button_index)
				report($sformatf("button_index %0d, expected %0d",
					got.button_index, want.button_index));
			if (got.last_of_run !== want.last_of_run)
				report($sformatf("last_of_run %0b, expected %0b",
					got.last_of_run, want.last_of_run));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_enabled   = RST_ENABLED;
			debounce_ms = RST_DEBOUNCE;
			window_ms   = RST_DOUBLE;
			repeat_ms   = RST_HOLD;
			long_ms     = RST_LONG;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				btn_phase[b]  = PH_IDLE;
				pressed_at[b] = '0;
				held_at[b]    = '0;
			end
			click_armed = 1'b0;
			armed_at    = '0;
			expected_q.delete();
			fail_count  = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_ENABLED:  n_enabled   = cfg_data[1:0];
				CFG_DEBOUNCE: debounce_ms = cfg_data[15:0];
				CFG_DOUBLE:   window_ms   = cfg_data[15:0];
				CFG_HOLD:     repeat_ms   = cfg_data[15:0];
				CFG_LONG:     long_ms     = cfg_data[TIME_BITS-1:0];
				default: ;
				endcase
			end
			if (evt_valid && evt_ready)
				check_event(evt);
			if (tick_valid && tick_ready)
				predict_tick(tick);
			outstanding <= expected_q.size();
		end
	end

endmodule

// ===== verif/button_gesture_detector_core_test.sv =====
module button_gesture_detector_core_test;
	import bgd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 16;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_UNUSED = CFG_LONG + 1'b1;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     tick_valid = 1'b0;
	logic                     tick_ready;
	tick_t                    tick       = '0;
	logic                     evt_valid;
	logic                     evt_ready  = 1'b0;
	evt_t                     evt;
	logic                     cfg_valid  = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index  = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data   = '0;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned quiet_cycles = 0;
	int unsigned stall_left   = 0;
	bit          relaxed      = 1'b0;

	logic [15:0]            deb_ms;
	logic [15:0]            dbl_ms;
	logic [15:0]            hold_ms;
	logic [TIME_BITS-1:0]   long_ms;
	logic [TIME_BITS-1:0]   now_ms;
	logic [NUM_BUTTONS-1:0] held;
	logic [TIME_BITS-1:0]   next_toggle[NUM_BUTTONS];

	button_gesture_detector_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.tick       (tick),
		.evt_valid  (evt_valid),
		.evt_ready  (evt_ready),
		.evt        (evt),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	button_gesture_detector_core_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_valid  (tick_valid),
		.tick_ready  (tick_ready),
		.tick        (tick),
		.evt_valid   (evt_valid),
		.evt_ready   (evt_ready),
		.evt         (evt),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned gap_len();
		if ($urandom_range(0, 19) < 16)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (stall_left != 0) begin
			evt_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			evt_ready <= 1'b1;
			if (!relaxed && $urandom_range(0, 3) == 0)
				stall_left <= gap_len();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (tick_valid && tick_ready) || (evt_valid && evt_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("button_gesture_detector_core_test: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_tick(input logic [NUM_BUTTONS-1:0] lv, input logic [TIME_BITS-1:0] t);
		int unsigned gap;
		gap = (relaxed || $urandom_range(0, 1) == 0) ? 0 : gap_len();
		if (gap != 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_valid <= 1'b1;
		tick       <= '{levels: lv, now_ms: t};
		do @(posedge clk); while (!tick_ready);
	endtask

	// block idle: every predicted item seen, plus time for an event-free tick to finish
	task automatic wait_idle();
		tick_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [1:0] en, input logic [15:0] deb, input logic [15:0] dbl,
			input logic [15:0] hold, input logic [TIME_BITS-1:0] lng);
		set_reg(CFG_ENABLED, {30'($urandom), en});
		set_reg(CFG_DEBOUNCE, {16'($urandom), deb});
		set_reg(CFG_DOUBLE, {16'($urandom), dbl});
		set_reg(CFG_HOLD, {16'($urandom), hold});
		set_reg(CFG_LONG, lng);
		cfg_valid <= 1'b0;
		deb_ms  = deb;
		dbl_ms  = dbl;
		hold_ms = hold;
		long_ms = lng;
		relaxed = ($urandom_range(0, 3) == 0);
	endtask

	function automatic logic [TIME_BITS-1:0] press_span();
		case ($urandom_range(0, 9))
		0, 1:       return $urandom_range(0, deb_ms);
		2, 3, 4, 5: return deb_ms + $urandom_range(0, long_ms);
		default:    return deb_ms + long_ms + $urandom_range(0, 4 * hold_ms + 40);
		endcase
	endfunction

	function automatic logic [TIME_BITS-1:0] release_span();
		if ($urandom_range(0, 9) < 6)
			return $urandom_range(0, dbl_ms);
		return dbl_ms + $urandom_range(0, 2 * dbl_ms + 40);
	endfunction

	// press/release scripts per button, with occasional one-tick glitches
	task automatic run_gestures(input int unsigned count, input int unsigned step_lo,
			input int unsigned step_hi);
		int unsigned n;
		int unsigned b;
		int unsigned glitch;
		logic [NUM_BUTTONS-1:0] lv;
		held = '0;
		for (b = 0; b < NUM_BUTTONS; b++)
			next_toggle[b] = now_ms + $urandom_range(0, 60);
		for (n = 0; n < count; n++) begin
			now_ms = now_ms + $urandom_range(step_lo, step_hi);
			for (b = 0; b < NUM_BUTTONS; b++) begin
				if ($signed(now_ms - next_toggle[b]) >= 0) begin
					held[b] = !held[b];
					next_toggle[b] = now_ms + (held[b] ? press_span() : release_span());
				end
			end
			lv = ~held;
			if ($urandom_range(0, 9) == 0) begin
				glitch = $urandom_range(0, NUM_BUTTONS - 1);
				lv[glitch] = !lv[glitch];
			end
			send_tick(lv, now_ms);
		end
	endtask

	initial begin
		int k;
		logic [TIME_BITS-1:0] t0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: nothing scanned
		send_tick(3'b000, 32'd0);
		wait_idle();

		configure(2'd3, 16'd20, 16'd100, 16'd30, 32'd60);
		for (k = CFG_FIRST_UNUSED; k < (1 << CFG_IDX_BITS); k++)
			set_reg(k[CFG_IDX_BITS-1:0], $urandom);
		cfg_valid <= 1'b0;
		send_tick(3'b110, 32'd1000);
		send_tick(3'b111, 32'd1010);
		send_tick(3'b110, 32'd1020);
		send_tick(3'b110, 32'd1040);
		send_tick(3'b111, 32'd1050);
		send_tick(3'b000, 32'd1100);
		send_tick(3'b000, 32'd1120);
		send_tick(3'b000, 32'd1180);
		send_tick(3'b000, 32'd1210);
		send_tick(3'b000, 32'd1220);
		send_tick(3'b111, 32'd1230);
		send_tick(3'b111, 32'd1330);
		send_tick(3'b101, 32'd1400);
		send_tick(3'b101, 32'd1420);
		send_tick(3'b111, 32'd1430);
		send_tick(3'b011, 32'd1440);
		send_tick(3'b011, 32'd1460);
		send_tick(3'b111, 32'd1470);
		send_tick(3'b101, 32'hFFFF_FFF0);
		send_tick(3'b101, 32'h0000_0010);
		send_tick(3'b111, 32'h0000_0030);
		send_tick(3'b111, 32'h0000_00A0);
		wait_idle();

		now_ms = 32'hFFFF_FF00;
		relaxed = 1'b0;
		run_gestures(25, 5, 30);
		wait_idle();

		configure(2'd3, 16'd0, 16'd0, 16'd0, 32'd0);
		run_gestures(15, 1, 20);
		wait_idle();

		configure(2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		t0 = 32'h7FFF_FF00;
		send_tick(3'b111, t0);
		send_tick(3'b110, t0);
		send_tick(3'b110, t0 + 32'd65534);
		send_tick(3'b110, t0 + 32'd65535);
		send_tick(3'b110, t0 + 32'd65534);
		send_tick(3'b110, t0 + 32'd131069);
		send_tick(3'b111, t0 + 32'd131070);
		send_tick(3'b111, t0 + 32'd196605);
		for (k = 0; k < 12; k++)
			send_tick(NUM_BUTTONS'($urandom), $urandom);
		wait_idle();

		configure(2'd2, 16'($urandom_range(5, 30)), 16'($urandom_range(30, 120)),
			16'($urandom_range(10, 50)), 32'($urandom_range(30, 150)));
		now_ms = $urandom;
		run_gestures(25, 5, 30);
		wait_idle();

		// pending click expires after scanning is switched off
		configure(2'd3, RST_DEBOUNCE, RST_DOUBLE, RST_HOLD, RST_LONG);
		send_tick(3'b111, 32'd5000);
		send_tick(3'b110, 32'd5010);
		send_tick(3'b110, 32'd5060);
		send_tick(3'b111, 32'd5070);
		wait_idle();
		set_reg(CFG_ENABLED, 32'd0);
		cfg_valid <= 1'b0;
		send_tick(3'b111, 32'd5400);
		wait_idle();

		if (fail_count == 0 && outstanding == 0)
			$display("button_gesture_detector_core_test: PASS");
		else
			$display("button_gesture_detector_core_test: FAIL");
		$finish;
	end

endmodule
